// ===== hdl/s256c_pkg.sv =====
// Shared constants, types and functions for the SHA-256 block compression.
package s256c_pkg;
	localparam int WordW = 32;
	localparam int HashWords = 8;
	localparam int BlockWords = 16;
	localparam int Rounds = 64;
	localparam int QueueDepth = 2;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		word_t w;
		logic  start;
	} in_item_t;

	typedef struct packed {
		word_t      hash_word;
		logic [2:0] hash_index;
		logic       last;
	} out_item_t;

	localparam word_t IvReset [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_ROUND = 3'b010,
		ST_EMIT  = 3'b100
	} core_state_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction
endpackage

// ===== hdl/s256c_if.sv =====
// Valid/ready channel interfaces for message words and hash words.
interface s256c_in_if;
	import s256c_pkg::*;
	logic       valid;
	logic       ready;
	word_t      message_word;
	logic       message_start;
	modport source (output valid, message_word, message_start, input ready);
	modport sink (input valid, message_word, message_start, output ready);
endinterface

interface s256c_out_if;
	import s256c_pkg::*;
	logic       valid;
	logic       ready;
	word_t      hash_word;
	logic [2:0] hash_index;
	logic       last;
	modport source (output valid, hash_word, hash_index, last, input ready);
	modport sink (input valid, hash_word, hash_index, last, output ready);
endinterface

// ===== hdl/s256c_queue.sv =====
// Short FIFO between the word front end and the compression core.
module s256c_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  s256c_pkg::in_item_t  push_data,
	output logic                 full,
	input  logic                 pop,
	output s256c_pkg::in_item_t  pop_data,
	output logic                 empty
);
	import s256c_pkg::*;

	in_item_t  mem_q [QueueDepth];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'(QueueDepth));
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) wr_ptr_q <= ~wr_ptr_q;
			if (pop && !empty) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

// ===== hdl/s256c_core.sv =====
// Compression core: schedule window, one round a cycle, hash update and output.
module s256c_core (
	input  logic                clk,
	input  logic                arst_n,
	input  s256c_pkg::word_t    iv [8],
	input  logic                q_empty,
	input  s256c_pkg::in_item_t q_data,
	output logic                q_pop,
	s256c_out_if.source         hout
);
	import s256c_pkg::*;

	core_state_t state_q;
	word_t       hash_q [HashWords];
	word_t       w_q [BlockWords];
	word_t       v_q [HashWords];
	logic [3:0]  pos_q;
	logic [5:0]  round_q;
	logic [2:0]  emit_q;

	word_t wt, g0, g1, s0, s1, ch, maj, t1, t2;

	// window slot 0 always holds W[t]; it shifts down each round
	always_comb begin
		g0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		g1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wt  = w_q[0];
		s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + s1 + ch + RoundK[round_q] + wt;
		s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2  = s0 + maj;
	end

	assign q_pop            = (state_q == ST_LOAD) && !q_empty;
	assign hout.valid       = (state_q == ST_EMIT);
	assign hout.hash_word   = hash_q[emit_q];
	assign hout.hash_index  = emit_q;
	assign hout.last        = (emit_q == 3'd7);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			w_q[pos_q] <= q_data.w;
			if (pos_q == 4'd15)
				for (int i = 0; i < HashWords; i++)
					v_q[i] <= (pos_q == 4'd0 && q_data.start) ? iv[i] : hash_q[i];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BlockWords-1] <= w_q[0] + g0 + w_q[9] + g1;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pos_q   <= 4'd0;
			round_q <= 6'd0;
			emit_q  <= 3'd0;
			for (int i = 0; i < HashWords; i++) hash_q[i] <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (pos_q == 4'd0 && q_data.start)
							for (int i = 0; i < HashWords; i++) hash_q[i] <= iv[i];
						pos_q <= pos_q + 4'd1;
						if (pos_q == 4'd15) state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(Rounds - 1)) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hash add was done at the last round edge
					if (hout.ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			if (state_q == ST_ROUND && round_q == 6'(Rounds - 1)) begin
				hash_q[0] <= hash_q[0] + t1 + t2;
				hash_q[1] <= hash_q[1] + v_q[0];
				hash_q[2] <= hash_q[2] + v_q[1];
				hash_q[3] <= hash_q[3] + v_q[2];
				hash_q[4] <= hash_q[4] + v_q[3] + t1;
				hash_q[5] <= hash_q[5] + v_q[4];
				hash_q[6] <= hash_q[6] + v_q[5];
				hash_q[7] <= hash_q[7] + v_q[6];
			end
		end
	end
endmodule

// ===== hdl/sha256_block_compression.sv =====
// Top level of the SHA-256 block compression.
// Use: message words enter on msg (valid/ready), big-endian, 16 to a block.
// message_start on the first word of a block reloads the chaining hash from
// the initial_hash registers; elsewhere it is ignored. Without it the
// chaining hash starts at zero after reset.
// After the 16th word the core runs 64 rounds, one a cycle, then presents
// the eight hash words H0..H7 on hash, last set on H7.
// Blocks are handled one at a time: the core loads the next block's words
// only after H7 of the previous block has been taken on hash.
// A two-entry queue takes words while the core is busy, so the sender runs
// ahead of the core. If the receiver stalls, H words hold and the core waits
// in output; the queue fills and ready drops.
// Reset (arst_n low) empties the queue, zeroes the chaining hash and loads
// the standard IV into the initial_hash registers. Write those registers
// through cfg_we/cfg_index/cfg_data only while the block is idle.
module sha256_block_compression (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	s256c_in_if.sink    msg,
	s256c_out_if.source hash
);
	import s256c_pkg::*;

	word_t    iv_q [HashWords];
	in_item_t push_data, pop_data;
	logic     full, empty, pop;

	assign msg.ready       = !full;
	assign push_data.w     = msg.message_word;
	assign push_data.start = msg.message_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HashWords; i++) iv_q[i] <= IvReset[i];
		end else if (cfg_we) begin
			iv_q[cfg_index] <= cfg_data;
		end
	end

	s256c_queue u_queue (
		.clk, .arst_n,
		.push(msg.valid), .push_data, .full,
		.pop, .pop_data, .empty
	);

	s256c_core u_core (
		.clk, .arst_n,
		.iv(iv_q), .q_empty(empty), .q_data(pop_data), .q_pop(pop),
		.hout(hash)
	);
endmodule

// ===== bench/sha256_block_compression_tb.sv =====
// Self-checking bench for the SHA-256 block compression: word transfers in, hash words out.
`timescale 1ns / 100ps
module sha256_block_compression_tb;
	import s256c_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	s256c_in_if  msg ();
	s256c_out_if hash ();

	sha256_block_compression uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .msg(msg.sink), .hash(hash.source)
	);

	always #1 clk = ~clk;

	// predictor state
	word_t     iv_regs [HashWords];
	word_t     chain [HashWords];
	word_t     window [BlockWords];
	int        word_pos;
	out_item_t hash_expected [$];
	in_item_t  word_pending [$];

	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	bit  src_hold = 1'b0;
	bit  in_fired = 1'b0;
	int  errors = 0;
	int  cycles = 0;
	int  words_sent = 0;
	int  hashes_seen = 0;

	function automatic word_t ror(word_t x, int n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic void compress_predict();
		word_t w [BlockWords];
		word_t v [HashWords];
		word_t wt, g0, g1, t1, t2;
		out_item_t o;
		w = window;
		v = chain;
		for (int r = 0; r < Rounds; r++) begin
			if (r < BlockWords) begin
				wt = w[r];
			end else begin
				g0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
				g1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
				wt = w[r&15] + g0 + w[(r-7)&15] + g1;
				w[r&15] = wt;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + wt;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < HashWords; i++) begin
			chain[i] = chain[i] + v[i];
			o.hash_word = chain[i];
			o.hash_index = 3'(i);
			o.last = (i == HashWords - 1);
			hash_expected.push_back(o);
		end
	endfunction

	function automatic void absorb_word(in_item_t it);
		if (word_pos == 0 && it.start)
			chain = iv_regs;
		window[word_pos] = it.w;
		word_pos = (word_pos + 1) % BlockWords;
		if (word_pos == 0)
			compress_predict();
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!msg.valid || in_fired) begin
				if (word_pending.size() > 0 && !src_hold
						&& $urandom_range(99) >= src_idle_pct) begin
					msg.valid <= 1'b1;
					msg.message_word <= word_pending[0].w;
					msg.message_start <= word_pending[0].start;
					void'(word_pending.pop_front());
				end else begin
					msg.valid <= 1'b0;
				end
			end
			hash.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		in_item_t it;
		out_item_t e;
		cycles <= cycles + 1;
		in_fired = arst_n && msg.valid && msg.ready;
		if (in_fired) begin
			it.w = msg.message_word;
			it.start = msg.message_start;
			absorb_word(it);
			words_sent <= words_sent + 1;
		end
		if (arst_n && hash.valid && hash.ready) begin
			hashes_seen <= hashes_seen + 1;
			if (hash_expected.size() == 0) begin
				$error("unexpected hash transfer word=%h", hash.hash_word);
				errors++;
			end else begin
				e = hash_expected.pop_front();
				if (hash.hash_word !== e.hash_word) begin
					$error("hash_word exp %h got %h", e.hash_word, hash.hash_word);
					errors++;
				end
				if (hash.hash_index !== e.hash_index) begin
					$error("hash_index exp %0d got %0d", e.hash_index, hash.hash_index);
					errors++;
				end
				if (hash.last !== e.last) begin
					$error("last exp %0b got %0b", e.last, hash.last);
					errors++;
				end
			end
		end
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("sha256_block_compression verification failed");
			$finish;
		end
	end

	task automatic queue_word(word_t w, bit s);
		in_item_t it;
		it.w = w;
		it.start = s;
		word_pending.push_back(it);
	endtask

	task automatic queue_block(bit s, int kind);
		for (int i = 0; i < BlockWords; i++) begin
			case (kind)
				0: queue_word('0, i == 0 ? s : 1'b0);
				1: queue_word('1, i == 0 ? s : 1'b1);
				default: queue_word($urandom, i == 0 ? s : 1'($urandom));
			endcase
		end
	endtask

	task automatic wait_drained();
		while (word_pending.size() > 0 || msg.valid || hash_expected.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_iv(int idx, word_t v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 3'(idx);
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		iv_regs[idx] = v;
	endtask

	initial begin
		iv_regs = IvReset;
		chain = '{default: '0};
		window = '{default: '0};
		word_pos = 0;
		msg.valid = 1'b0;
		msg.message_word = '0;
		msg.message_start = 1'b0;
		hash.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zeros on zero chain, ones with reset IV, then a chained random block
		queue_block(1'b0, 0);
		wait_drained();
		queue_block(1'b1, 1);
		queue_block(1'b0, 2);
		// sender pauses while the first block's hash words are still due
		while (hash_expected.size() == 0) @(posedge clk);
		src_hold = 1'b1;
		while (hash_expected.size() > 0) @(posedge clk);
		src_hold = 1'b0;
		wait_drained();

		// phases of random blocks under differing IVs and idle mixes
		for (int ph = 0; ph < 3; ph++) begin
			for (int i = 0; i < HashWords; i++)
				write_iv(i, ph == 0 ? '0 : ph == 1 ? '1 : $urandom);
			case (ph)
				0: begin src_idle_pct = 25; snk_idle_pct = 65; end
				1: begin src_idle_pct = 65; snk_idle_pct = 25; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			for (int b = 0; b < 2; b++)
				queue_block(b == 0 ? 1'b1 : 1'($urandom), 2);
			wait_drained();
		end

		$display("covered %0d word transfers and %0d hash words over four IV settings",
			words_sent, hashes_seen);
		if (errors == 0)
			$display("sha256_block_compression verification clean");
		else
			$display("sha256_block_compression verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/s256c_pkg.sv
hdl/s256c_if.sv
hdl/s256c_queue.sv
hdl/s256c_core.sv
hdl/sha256_block_compression.sv
bench/sha256_block_compression_tb.sv
